// ----- hw/rtl/snh_pkg.sv -----
// ----------------------------------------------------------------------------
// snh_pkg
// Types and constants shared by the string nibble hash modules.
// ----------------------------------------------------------------------------
package snh_pkg;

    // queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_LVL_W = 3;

    // width of the count field of a result word
    localparam int RES_W = 16;

    // byte codes
    localparam logic [7:0] BYTE_NUL   = 8'h00;
    localparam logic [7:0] BYTE_LF    = 8'h0A;
    localparam logic [7:0] BYTE_SPACE = 8'h20;
    localparam logic [7:0] BYTE_ZERO  = 8'h30;
    localparam logic [7:0] BYTE_NINE  = 8'h39;
    localparam logic [7:0] BYTE_UC_A  = 8'h41;
    localparam logic [7:0] BYTE_UC_Z  = 8'h5A;
    localparam logic [7:0] BYTE_LC_A  = 8'h61;
    localparam logic [7:0] BYTE_LC_Z  = 8'h7A;
    localparam logic [7:0] CASE_MASK  = 8'hDF;

    // last emitted code before any was emitted
    localparam logic [4:0] NONE_YET = 5'h10;

    localparam int         TABLE_LEN   = 36;
    localparam logic [5:0] ALPHA_BASE  = 6'd10;

    // '0'..'9' then 'A'..'Z'
    localparam logic [3:0] CODE_TABLE [TABLE_LEN] = '{
        4'd0,  4'd1,  4'd2,  4'd3,  4'd4,  4'd5,  4'd6,  4'd7,  4'd8,  4'd9,
        4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15, 4'd1,  4'd2,  4'd3,  4'd1,
        4'd12, 4'd4,  4'd5,  4'd6,  4'd7,  4'd8,  4'd9,  4'd10, 4'd11, 4'd12,
        4'd13, 4'd14, 4'd13, 4'd2,  4'd3,  4'd15
    };

    // one queued result: a code (value[3:0]) or the end word (value = count)
    typedef struct packed {
        logic             is_end;
        logic [RES_W-1:0] value;
    } t_entry;

    // words pushed by the front in one cycle, e0 first
    typedef struct packed {
        logic [1:0] num;
        t_entry     e0;
        t_entry     e1;
    } t_push;

    typedef struct packed {
        logic               has_room;
        logic [Q_LVL_W-1:0] level;
    } t_q_status;

    typedef struct packed {
        logic   valid;
        t_entry head;
    } t_q_head;

endpackage

// ----- hw/rtl/snh_in_if.sv -----
// ----------------------------------------------------------------------------
// snh_in_if
// Byte channel into the string nibble hash: valid, ready and one byte.
// ----------------------------------------------------------------------------
interface snh_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

// ----- hw/rtl/snh_out_if.sv -----
// ----------------------------------------------------------------------------
// snh_out_if
// Result channel of the string nibble hash: valid, ready and one result word.
// ----------------------------------------------------------------------------
interface snh_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  code_nibble;
    logic        string_end;
    logic [15:0] emitted_count;

    modport source (output valid, output code_nibble, output string_end,
                    output emitted_count, input ready);
    modport sink   (input valid, input code_nibble, input string_end,
                    input emitted_count, output ready);
endinterface

// ----- hw/rtl/snh_front.sv -----
// ----------------------------------------------------------------------------
// snh_front
// Accepts bytes, classifies them, keeps the hash state and pushes up to two
// result words per byte into the queue.
// ----------------------------------------------------------------------------
module snh_front #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    snh_in_if.sink              i_byte,
    input  snh_pkg::t_q_status  i_q_status,
    output snh_pkg::t_push      o_push
);

    logic [7:0]             r_sum;
    logic                   r_in_run;
    logic [4:0]             r_last;
    logic [COUNT_WIDTH-1:0] r_total;

    logic [7:0]             n_sum;
    logic                   n_in_run;
    logic [4:0]             n_last;
    logic [COUNT_WIDTH-1:0] n_total;

    logic                   accept;
    logic [7:0]             b;
    logic [7:0]             up;
    logic                   is_term;
    logic                   is_digit;
    logic                   is_alpha;
    logic                   is_ctrl;
    logic                   is_punct;
    logic                   is_own;
    logic [7:0]             diff;
    logic [5:0]             idx;
    logic [3:0]             own_code;
    logic [3:0]             run_code;
    logic                   close_run;
    logic                   emit1;
    logic                   emit2;
    logic [4:0]             last1;
    logic [COUNT_WIDTH-1:0] total1;
    logic [COUNT_WIDTH-1:0] total2;
    logic [COUNT_WIDTH+snh_pkg::RES_W-1:0] count_ext;
    snh_pkg::t_entry        run_entry;
    snh_pkg::t_entry        own_entry;
    snh_pkg::t_entry        end_entry;

    assign i_byte.ready = i_q_status.has_room;
    assign accept       = i_byte.valid && i_byte.ready;

    always_comb begin
        b        = i_byte.in_byte;
        up       = b & snh_pkg::CASE_MASK;
        is_term  = (b == snh_pkg::BYTE_NUL) || (b == snh_pkg::BYTE_LF);
        is_digit = (b >= snh_pkg::BYTE_ZERO) && (b <= snh_pkg::BYTE_NINE);
        is_alpha = ((b >= snh_pkg::BYTE_UC_A) && (b <= snh_pkg::BYTE_UC_Z))
                || ((b >= snh_pkg::BYTE_LC_A) && (b <= snh_pkg::BYTE_LC_Z));
        is_ctrl  = (b < snh_pkg::BYTE_SPACE);
        is_punct = !is_digit && !is_alpha && !is_ctrl;
        is_own   = is_digit || is_alpha;

        // table index: digits first, then letters
        if (is_digit) begin
            diff = b - snh_pkg::BYTE_ZERO;
            idx  = diff[5:0];
        end else begin
            diff = up - snh_pkg::BYTE_UC_A;
            idx  = snh_pkg::ALPHA_BASE + diff[5:0];
        end
        own_code = (idx < 6'(snh_pkg::TABLE_LEN)) ? snh_pkg::CODE_TABLE[idx] : 4'd0;

        run_code  = r_sum[7:4] ^ r_sum[3:0];
        close_run = r_in_run && !is_punct;

        emit1  = close_run && ({1'b0, run_code} != r_last);
        last1  = emit1 ? {1'b0, run_code} : r_last;
        emit2  = is_own && ({1'b0, own_code} != last1);

        total1 = (emit1 && (r_total != '1)) ? r_total + 1'b1 : r_total;
        total2 = (emit2 && (total1 != '1)) ? total1 + 1'b1 : total1;

        count_ext = {{snh_pkg::RES_W{1'b0}}, r_total};

        run_entry.is_end = 1'b0;
        run_entry.value  = {{(snh_pkg::RES_W-4){1'b0}}, run_code};
        own_entry.is_end = 1'b0;
        own_entry.value  = {{(snh_pkg::RES_W-4){1'b0}}, own_code};
        end_entry.is_end = 1'b1;
        end_entry.value  = count_ext[snh_pkg::RES_W-1:0];

        n_sum    = r_sum;
        n_in_run = r_in_run;
        n_last   = r_last;
        n_total  = r_total;
        o_push.num = 2'd0;
        o_push.e0  = own_entry;
        o_push.e1  = own_entry;

        if (accept) begin
            if (is_term) begin
                n_sum      = '0;
                n_in_run   = 1'b0;
                n_last     = snh_pkg::NONE_YET;
                n_total    = '0;
                o_push.num = 2'd1;
                o_push.e0  = end_entry;
            end else begin
                n_sum = close_run ? 8'd0 : r_sum;
                if (is_punct) begin
                    n_sum = r_sum + b;
                end
                n_in_run   = is_punct;
                n_last     = emit2 ? {1'b0, own_code} : last1;
                n_total    = total2;
                o_push.num = {1'b0, emit1} + {1'b0, emit2};
                o_push.e0  = emit1 ? run_entry : own_entry;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum    <= '0;
            r_in_run <= 1'b0;
            r_last   <= snh_pkg::NONE_YET;
            r_total  <= '0;
        end else begin
            r_sum    <= n_sum;
            r_in_run <= n_in_run;
            r_last   <= n_last;
            r_total  <= n_total;
        end
    end

endmodule

// ----- hw/rtl/snh_queue.sv -----
// ----------------------------------------------------------------------------
// snh_queue
// Short result queue between front and back: up to two words in, one out.
// ----------------------------------------------------------------------------
module snh_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  snh_pkg::t_push      i_push,
    input  logic                i_pop,
    output snh_pkg::t_q_head    o_head,
    output snh_pkg::t_q_status  o_status
);

    snh_pkg::t_entry              r_mem [snh_pkg::Q_DEPTH];
    logic [snh_pkg::Q_PTR_W-1:0]  r_wr_ptr;
    logic [snh_pkg::Q_PTR_W-1:0]  r_rd_ptr;
    logic [snh_pkg::Q_LVL_W-1:0]  r_level;

    logic [snh_pkg::Q_PTR_W-1:0]  wr_ptr1;
    logic                         pop;

    assign wr_ptr1 = r_wr_ptr + 1'b1;
    assign pop     = i_pop && (r_level != '0);

    assign o_head.valid      = (r_level != '0);
    assign o_head.head       = r_mem[r_rd_ptr];
    // room for a byte that makes two words
    assign o_status.has_room = (r_level <= snh_pkg::Q_LVL_W'(snh_pkg::Q_DEPTH - 2));
    assign o_status.level    = r_level;

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.e0;
        end
        if (i_push.num == 2'd2) begin
            r_mem[wr_ptr1] <= i_push.e1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + snh_pkg::Q_PTR_W'(i_push.num);
            r_rd_ptr <= r_rd_ptr + snh_pkg::Q_PTR_W'(pop);
            r_level  <= r_level + snh_pkg::Q_LVL_W'(i_push.num)
                                - snh_pkg::Q_LVL_W'(pop);
        end
    end

endmodule

// ----- hw/rtl/snh_back.sv -----
// ----------------------------------------------------------------------------
// snh_back
// Takes words from the queue and holds them in the output register until
// the receiver takes them.
// ----------------------------------------------------------------------------
module snh_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  snh_pkg::t_q_head  i_head,
    output logic              o_pop,
    snh_out_if.source         o_result
);

    logic        r_valid;
    logic [3:0]  r_nibble;
    logic        r_end;
    logic [15:0] r_count;

    // load when the register is empty or being taken
    assign o_pop = i_head.valid && (!r_valid || o_result.ready);

    assign o_result.valid         = r_valid;
    assign o_result.code_nibble   = r_nibble;
    assign o_result.string_end    = r_end;
    assign o_result.emitted_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_end <= i_head.head.is_end;
            if (i_head.head.is_end) begin
                r_nibble <= 4'd0;
                r_count  <= i_head.head.value;
            end else begin
                r_nibble <= i_head.head.value[3:0];
                r_count  <= 16'd0;
            end
        end
    end

endmodule

// ----- hw/rtl/string_nibble_hash.sv -----
// ----------------------------------------------------------------------------
// string_nibble_hash
// Hashes a byte string into a stream of 4-bit codes plus an end word.
//
// i_byte takes one string byte per word; 0 or 10 ends the string. o_result
// gives one word per emitted code (string_end = 0) and one end word per
// string (string_end = 1, emitted_count = codes emitted, saturating).
// Letters and digits map to codes through a table, punctuation runs are
// summed and folded into one code, repeats of the last code are dropped.
// Words pass through the queue, then the output register, to o_result; a
// byte that closes a run pushes both its words into the queue together.
// Throughput: one byte per cycle while each byte gives at most one word and
// the receiver takes every word; output is one word per cycle while ready is
// high, set by the output register. i_byte.ready drops when the four-word
// queue holds more than two words. Reset clears the hash state and empties
// queue and output register. When the receiver stalls, the output word holds
// and the queue fills, then i_byte.ready falls.
// ----------------------------------------------------------------------------
module string_nibble_hash #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    snh_in_if.sink     i_byte,
    snh_out_if.source  o_result
);

    snh_pkg::t_push      push;
    snh_pkg::t_q_status  q_status;
    snh_pkg::t_q_head    q_head;
    logic                pop;

    snh_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte     (i_byte),
        .i_q_status (q_status),
        .o_push     (push)
    );

    snh_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_pop    (pop),
        .o_head   (q_head),
        .o_status (q_status)
    );

    snh_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (q_head),
        .o_pop    (pop),
        .o_result (o_result)
    );

`ifndef NO_ASSERTIONS
    // the queue never holds more than its depth
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.level <= snh_pkg::Q_LVL_W'(snh_pkg::Q_DEPTH))
        else $error("result queue overflow");

    // a terminator pushes exactly the end word
    a_term_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_byte.valid && i_byte.ready
            && (i_byte.in_byte == snh_pkg::BYTE_NUL || i_byte.in_byte == snh_pkg::BYTE_LF))
        |-> (push.num == 2'd1 && push.e0.is_end))
        else $error("terminator did not push a single end word");

    // pushes only happen when there is room for them
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.num != 2'd0) |-> q_status.has_room)
        else $error("push into a full queue");

    // an end word carries a zero code
    a_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.string_end) |-> (o_result.code_nibble == 4'd0))
        else $error("end word with nonzero code");
`endif

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives byte strings into string_nibble_hash and checks every result word
// against a cycle-free predictor of the hash. A short directed table covers
// letters, digits, control bytes, punctuation runs and terminators, then
// random strings follow, two of them long ones with a code on every byte.
// Both sides idle at random; the receiver also holds off once for a long
// stretch so the result queue fills and the byte input stalls.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CNT_W        = 16;
    localparam int N_ITEMS      = 1550;
    localparam int N_DIRECTED   = 25;
    localparam int IDLE_PCT     = 20;
    localparam int HOLD_CYCLES  = 120;
    localparam int HOLD_AT      = 150;
    localparam int DRAIN_CYCLES = 10;
    localparam int MAX_REPORTS  = 10;

    // codes for '0'..'9' then 'A'..'Z'
    localparam logic [3:0] HASH_CODE [36] = '{
        4'd0,  4'd1,  4'd2,  4'd3,  4'd4,  4'd5,  4'd6,  4'd7,  4'd8,  4'd9,
        4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15, 4'd1,  4'd2,  4'd3,  4'd1,
        4'd12, 4'd4,  4'd5,  4'd6,  4'd7,  4'd8,  4'd9,  4'd10, 4'd11, 4'd12,
        4'd13, 4'd14, 4'd13, 4'd2,  4'd3,  4'd15
    };

    typedef struct packed {
        logic [3:0]  code;
        logic        fin;
        logic [15:0] cnt;
    } t_hash_word;

    // typed = 1: the words below are the expectation, else the predictor's
    typedef struct packed {
        logic [7:0] b;
        logic       typed;
        logic [1:0] n;
        t_hash_word w0;
        t_hash_word w1;
    } t_stim_row;

    localparam t_hash_word NO_W = '0;

    localparam t_stim_row DIRECTED [N_DIRECTED] = '{
        '{8'h00, 1'b1, 2'd1, '{4'd0, 1'b1, 16'd0}, NO_W},    // empty string
        '{8'h0A, 1'b1, 2'd1, '{4'd0, 1'b1, 16'd0}, NO_W},    // empty string, lf
        '{8'h30, 1'b1, 2'd1, '{4'd0, 1'b0, 16'd0}, NO_W},    // '0'
        '{8'h39, 1'b1, 2'd1, '{4'd9, 1'b0, 16'd0}, NO_W},    // '9'
        '{8'h41, 1'b1, 2'd1, '{4'd10, 1'b0, 16'd0}, NO_W},   // 'A'
        '{8'h7A, 1'b1, 2'd1, '{4'd15, 1'b0, 16'd0}, NO_W},   // 'z'
        '{8'h5A, 1'b1, 2'd0, NO_W, NO_W},                    // 'Z' repeats 15
        '{8'h01, 1'b1, 2'd0, NO_W, NO_W},                    // control, no run
        '{8'h21, 1'b1, 2'd0, NO_W, NO_W},                    // '!' opens run
        '{8'hFF, 1'b1, 2'd0, NO_W, NO_W},
        '{8'h61, 1'b1, 2'd2, '{4'd2, 1'b0, 16'd0}, '{4'd10, 1'b0, 16'd0}},
        '{8'h7F, 1'b1, 2'd0, NO_W, NO_W},                    // del is punctuation
        '{8'h1F, 1'b1, 2'd1, '{4'd8, 1'b0, 16'd0}, NO_W},    // control closes run
        '{8'h80, 1'b0, 2'd0, NO_W, NO_W},
        '{8'h40, 1'b0, 2'd0, NO_W, NO_W},
        '{8'h5B, 1'b0, 2'd0, NO_W, NO_W},
        '{8'h60, 1'b0, 2'd0, NO_W, NO_W},
        '{8'h7B, 1'b0, 2'd0, NO_W, NO_W},
        '{8'h2F, 1'b0, 2'd0, NO_W, NO_W},
        '{8'h3A, 1'b0, 2'd0, NO_W, NO_W},
        '{8'h00, 1'b1, 2'd1, '{4'd0, 1'b1, 16'd7}, NO_W},    // trailing run dropped
        '{8'hE1, 1'b0, 2'd0, NO_W, NO_W},
        '{8'h20, 1'b0, 2'd0, NO_W, NO_W},
        '{8'h62, 1'b0, 2'd0, NO_W, NO_W},
        '{8'h0A, 1'b0, 2'd0, NO_W, NO_W}
    };

    logic i_clk;
    logic i_rst_n;

    snh_in_if  byte_if ();
    snh_out_if res_if ();

    string_nibble_hash #(
        .COUNT_WIDTH (CNT_W)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (byte_if),
        .o_result (res_if)
    );

    // hash state mirror
    logic [7:0]       run_sum;
    logic             run_open;
    logic [4:0]       prev_code;
    logic [CNT_W-1:0] code_cnt;

    t_hash_word expected_words [$];
    int         n_sent;
    int         n_results;
    int         n_errors;
    int         hold_left;
    logic       hold_done;

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    task automatic emit_code(input logic [4:0] c, inout int n,
                             inout t_hash_word w0, inout t_hash_word w1);
        t_hash_word w;
        if (c != prev_code) begin
            prev_code = c;
            if (code_cnt != {CNT_W{1'b1}}) code_cnt = code_cnt + 1'b1;
            w = '{c[3:0], 1'b0, 16'd0};
            if (n == 0) w0 = w;
            else w1 = w;
            n = n + 1;
        end
    endtask

    task automatic predict_byte(input logic [7:0] b, output int n,
                                output t_hash_word w0, output t_hash_word w1);
        logic [7:0] up;
        logic       is_dig;
        logic       is_alpha;
        logic       is_punct;
        logic [5:0] idx;
        n  = 0;
        w0 = NO_W;
        w1 = NO_W;
        if (b == snh_pkg::BYTE_NUL || b == snh_pkg::BYTE_LF) begin
            w0.fin = 1'b1;
            w0.cnt[CNT_W-1:0] = code_cnt;
            n = 1;
            run_sum   = '0;
            run_open  = 1'b0;
            prev_code = snh_pkg::NONE_YET;
            code_cnt  = '0;
        end else begin
            up       = (b >= snh_pkg::BYTE_LC_A) ? (b & snh_pkg::CASE_MASK) : b;
            is_dig   = (b >= snh_pkg::BYTE_ZERO) && (b <= snh_pkg::BYTE_NINE);
            is_alpha = ((b >= snh_pkg::BYTE_UC_A) && (b <= snh_pkg::BYTE_UC_Z)) ||
                       ((b >= snh_pkg::BYTE_LC_A) && (b <= snh_pkg::BYTE_LC_Z));
            is_punct = !is_dig && !is_alpha && (b >= snh_pkg::BYTE_SPACE);
            if (run_open && !is_punct) begin
                emit_code({1'b0, run_sum[7:4] ^ run_sum[3:0]}, n, w0, w1);
                run_sum = '0;
            end
            if (is_dig) begin
                idx = 6'(b - snh_pkg::BYTE_ZERO);
                emit_code({1'b0, HASH_CODE[idx]}, n, w0, w1);
            end else if (is_alpha) begin
                idx = 6'(up - snh_pkg::BYTE_UC_A) + 6'd10;
                emit_code({1'b0, HASH_CODE[idx]}, n, w0, w1);
            end else if (is_punct) begin
                run_sum = run_sum + b;
            end
            run_open = is_punct;
        end
    endtask

    // offers one byte, waits for it to be taken, queues what it should give
    task automatic send_byte(input logic [7:0] b, input logic typed, input logic [1:0] tn,
                             input t_hash_word t0, input t_hash_word t1);
        int         n;
        t_hash_word w0;
        t_hash_word w1;
        while ((n_sent < 600 || n_sent >= 900) && $urandom_range(99) < IDLE_PCT) begin
            byte_if.valid = 1'b0;
            @(negedge i_clk);
        end
        byte_if.valid   = 1'b1;
        byte_if.in_byte = b;
        do @(posedge i_clk); while (!byte_if.ready);
        predict_byte(b, n, w0, w1);
        if (typed) begin
            n  = tn;
            w0 = t0;
            w1 = t1;
        end
        if (n > 0) expected_words.push_back(w0);
        if (n > 1) expected_words.push_back(w1);
        n_sent = n_sent + 1;
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] rand_body_byte();
        int k;
        logic [7:0] b;
        k = $urandom_range(99);
        if (k < 22) b = 8'($urandom_range(snh_pkg::BYTE_UC_Z, snh_pkg::BYTE_UC_A));
        else if (k < 40) b = 8'($urandom_range(snh_pkg::BYTE_LC_Z, snh_pkg::BYTE_LC_A));
        else if (k < 55) b = 8'($urandom_range(snh_pkg::BYTE_NINE, snh_pkg::BYTE_ZERO));
        else if (k < 75) begin
            case ($urandom_range(3))
                0:       b = 8'($urandom_range(8'h2F, 8'h20));
                1:       b = 8'($urandom_range(8'h40, 8'h3A));
                2:       b = 8'($urandom_range(8'h60, 8'h5B));
                default: b = 8'($urandom_range(8'h7F, 8'h7B));
            endcase
        end else if (k < 90) b = 8'($urandom_range(8'hFF, 8'h80));
        else begin
            b = 8'($urandom_range(8'h1F, 8'h01));
            if (b == snh_pkg::BYTE_LF) b = 8'h09;
        end
        return b;
    endfunction

    task automatic flag_error(input string what, input t_hash_word exp_w,
                              input t_hash_word got_w);
        n_errors = n_errors + 1;
        if (n_errors <= MAX_REPORTS)
            $display("mismatch %s: exp code %0d end %0d cnt %0d, got code %0d end %0d cnt %0d",
                     what, exp_w.code, exp_w.fin, exp_w.cnt, got_w.code, got_w.fin, got_w.cnt);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_hash_word got_w;
        t_hash_word exp_w;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got_w = '{res_if.code_nibble, res_if.string_end, res_if.emitted_count};
            n_results = n_results + 1;
            if (expected_words.size() == 0) begin
                flag_error("unexpected word", NO_W, got_w);
            end else begin
                exp_w = expected_words.pop_front();
                if (got_w.fin !== exp_w.fin) flag_error("string_end", exp_w, got_w);
                else if (got_w.code !== exp_w.code) flag_error("code_nibble", exp_w, got_w);
                else if (got_w.cnt !== exp_w.cnt) flag_error("emitted_count", exp_w, got_w);
            end
        end
    end

    // receiver: random stalls, one long hold-off, a stretch with none
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready = 1'b0;
        end else begin
            if (!hold_done && n_results >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left    = hold_left - 1;
                res_if.ready = 1'b0;
            end else if (n_results >= 300 && n_results < 500) begin
                res_if.ready = 1'b1;
            end else begin
                res_if.ready = ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

    initial begin
        int         len;
        int         str_idx;
        logic       long_str;
        logic [7:0] b;
        byte_if.valid   = 1'b0;
        byte_if.in_byte = 8'h00;
        res_if.ready    = 1'b0;
        n_sent    = 0;
        n_results = 0;
        n_errors  = 0;
        hold_left = 0;
        hold_done = 1'b0;
        run_sum   = '0;
        run_open  = 1'b0;
        prev_code = snh_pkg::NONE_YET;
        code_cnt  = '0;
        str_idx   = 0;
        i_rst_n   = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_byte(DIRECTED[i].b, DIRECTED[i].typed, DIRECTED[i].n,
                      DIRECTED[i].w0, DIRECTED[i].w1);

        while (n_sent < N_ITEMS) begin
            // two long strings alternate letter and digit codes for a high count
            long_str = (str_idx == 12 || str_idx == 70);
            if (long_str) len = $urandom_range(300, 262);
            else if ($urandom_range(9) == 0) len = 0;
            else len = $urandom_range(24, 1);
            for (int i = 0; i < len; i++) begin
                if (!long_str) b = rand_body_byte();
                else if (i % 2 == 1)
                    b = 8'($urandom_range(snh_pkg::BYTE_NINE, snh_pkg::BYTE_ZERO));
                else b = $urandom_range(1) ? snh_pkg::BYTE_UC_A : snh_pkg::BYTE_LC_A;
                send_byte(b, 1'b0, 2'd0, NO_W, NO_W);
            end
            send_byte($urandom_range(1) ? snh_pkg::BYTE_NUL : snh_pkg::BYTE_LF,
                      1'b0, 2'd0, NO_W, NO_W);
            str_idx = str_idx + 1;
        end
        byte_if.valid = 1'b0;

        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0 && expected_words.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
